[src/assert_macros.svh]
// Assertion macros shared by the RTL of the APD90 tracker.
// Uses clk_i and rst_ni of the including module; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled during reset.
`define APD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define APD_ASSERT_IMPL(label, ante, cons, msg) \
  `APD_ASSERT(label, (ante) |-> (cons), msg)

`endif

[src/apd_pkg.sv]
// Shared types and constants of the APD90 tracker.
// No dependencies; used by the top level, apd90_checker and the testbench.
package apd_pkg;

  localparam int unsigned NODES      = 1024;
  localparam int unsigned ADDR_W     = $clog2(NODES);
  localparam int unsigned NODE_W     = 10;
  localparam int unsigned VOLT_W     = 18;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 18;
  localparam int unsigned REST9_W    = 22;
  localparam int unsigned CMP_W      = 24;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RESTING   = CFG_IDX_W'(1);

  localparam logic signed [VOLT_W-1:0]  THRESHOLD_RST = '0;
  localparam logic signed [REST9_W-1:0] REST9_RST     = REST9_W'(-195840);

  typedef logic signed [VOLT_W-1:0] volt_t;

  typedef struct packed {
    logic              active;
    logic [TIME_W-1:0] stamp;
    volt_t             peak;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

[src/apd_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// Read during write to the same address returns the old data. No dependencies.
module apd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/action_potential_apd90_tracker_top.sv]
// Top level of the APD90 tracker: per-node activation, peak and duration.
// Depends on apd_pkg, apd_ram and assert_macros.svh.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_ready_o   | node_index, sample_voltage, sample_time
//   out     | output    | out_valid_o / out_ready_i | node, flags, peak, duration, any
//   cfg     | input     | cfg_we_i                | cfg_index_i, cfg_data_i
//
// One request per cycle unless the output stalls; a request passes stage 1, stage 2, output register.
// The per-node state memory is read on accept and written when stage 1 advances;
// a one-entry write-back register forwards the newest write.
// After reset a clearing pass writes all 1024 entries, one per cycle; in_ready_o stays low.
// A stall at the output holds every stage in place; nothing is lost or repeated.

`include "assert_macros.svh"

module action_potential_apd90_tracker_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [apd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [apd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [apd_pkg::NODE_W-1:0]       node_index_i,
  input  logic signed [apd_pkg::VOLT_W-1:0] sample_voltage_i,
  input  logic [apd_pkg::TIME_W-1:0]       sample_time_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [apd_pkg::NODE_W-1:0]       out_node_o,
  output logic                             activated_o,
  output logic                             deactivated_o,
  output logic                             is_active_o,
  output logic signed [apd_pkg::VOLT_W-1:0] peak_out_o,
  output logic [apd_pkg::TIME_W-1:0]       duration_out_o,
  output logic                             any_activated_o
);

  localparam int unsigned AW = apd_pkg::ADDR_W;
  localparam int unsigned CW = apd_pkg::CMP_W;
  localparam int unsigned TW = apd_pkg::TIME_W;

  // configuration
  apd_pkg::volt_t                       thr_q;
  logic signed [apd_pkg::REST9_W-1:0]   rest9_q;
  logic signed [apd_pkg::REST9_W-1:0]   rest9_d;
  logic signed [CW-1:0]                 rest_x9;

  // clearing pass
  logic          clr_q;
  logic [AW-1:0] clr_cnt_q;

  // stage valids and handshake
  logic p1_valid_q, p2_valid_q, out_valid_q;
  logic p1_ready, p2_ready, out_ready;
  logic accept, p1_adv, p2_adv;

  // stage 1 payload
  logic [apd_pkg::NODE_W-1:0] p1_node_q;
  apd_pkg::volt_t             p1_v_q;
  logic [TW-1:0]              p1_t_q;
  logic signed [CW-1:0]       p1_lhs_q;
  logic                       p1_inr_q;
  logic signed [CW-1:0]       v_ext, r_ext, lhs_d;

  // stage 1 compute
  logic [apd_pkg::ENTRY_W-1:0] rdata;
  apd_pkg::entry_t             cur, wr_entry;
  logic                        act, tracked, deact, new_active;
  apd_pkg::volt_t              base_peak, new_peak;
  logic [TW-1:0]               new_stamp;

  // write-back forwarding register
  logic                       wb_valid_q;
  logic [apd_pkg::NODE_W-1:0] wb_node_q;
  apd_pkg::entry_t            wb_entry_q;

  logic seen_q;

  // stage 2 payload
  logic [apd_pkg::NODE_W-1:0] p2_node_q;
  logic                       p2_act_q, p2_deact_q, p2_active_q, p2_any_q;
  apd_pkg::volt_t             p2_peak_q;
  logic [TW-1:0]              p2_t_q, p2_stamp_q;
  logic [TW:0]                diff;
  logic [TW-1:0]              dur_d;

  // output payload
  logic [apd_pkg::NODE_W-1:0] out_node_q;
  logic                       out_act_q, out_deact_q, out_active_q, out_any_q;
  apd_pkg::volt_t             out_peak_q;
  logic [TW-1:0]              out_dur_q;

  // memory ports
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [apd_pkg::ENTRY_W-1:0] ram_wdata;

  // ---------------------------------------------------------------- config
  assign rest_x9 = (CW'(signed'(cfg_data_i)) <<< 3) + CW'(signed'(cfg_data_i));
  assign rest9_d = rest_x9[apd_pkg::REST9_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= apd_pkg::THRESHOLD_RST;
      rest9_q <= apd_pkg::REST9_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        apd_pkg::REG_THRESHOLD: thr_q   <= apd_pkg::volt_t'(cfg_data_i);
        apd_pkg::REG_RESTING:   rest9_q <= rest9_d;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- handshake
  assign out_ready  = !out_valid_q || out_ready_i;
  assign p2_ready   = !p2_valid_q || out_ready;
  assign p1_ready   = !p1_valid_q || p2_ready;
  assign in_ready_o = p1_ready && !clr_q;
  assign accept     = in_valid_i && in_ready_o;
  assign p1_adv     = p1_valid_q && p2_ready;
  assign p2_adv     = p2_valid_q && out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q  <= 1'b0;
      p2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      clr_q       <= 1'b1;
      clr_cnt_q   <= '0;
      wb_valid_q  <= 1'b0;
      seen_q      <= 1'b0;
    end else begin
      if (p1_ready) begin
        p1_valid_q <= accept;
      end
      if (p2_ready) begin
        p2_valid_q <= p1_valid_q;
      end
      if (out_ready) begin
        out_valid_q <= p2_valid_q;
      end
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
        if (clr_cnt_q == AW'(apd_pkg::NODES - 1)) begin
          clr_q <= 1'b0;
        end
      end
      if (p1_adv && p1_inr_q) begin
        wb_valid_q <= 1'b1;
      end
      if (p1_adv) begin
        seen_q <= seen_q | act;
      end
    end
  end

  // ---------------------------------------------------------------- stage 1 load
  assign v_ext = CW'(sample_voltage_i);
  assign r_ext = CW'(rest9_q);
  assign lhs_d = (v_ext <<< 3) + (v_ext <<< 1) - r_ext;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p1_node_q <= node_index_i;
      p1_v_q    <= sample_voltage_i;
      p1_t_q    <= sample_time_i;
      p1_lhs_q  <= lhs_d;
      p1_inr_q  <= (32'(node_index_i) < apd_pkg::NODES);
    end
  end

  // ---------------------------------------------------------------- state memory
  assign ram_we    = clr_q || (p1_adv && p1_inr_q);
  assign ram_waddr = clr_q ? clr_cnt_q : p1_node_q[AW-1:0];
  assign ram_wdata = clr_q ? '0 : wr_entry;

  apd_ram #(
    .WIDTH (apd_pkg::ENTRY_W),
    .DEPTH (apd_pkg::NODES)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (node_index_i[AW-1:0]),
    .rdata_o (rdata)
  );

  // ---------------------------------------------------------------- stage 1 compute
  always_comb begin
    cur = (wb_valid_q && wb_node_q == p1_node_q) ? wb_entry_q : apd_pkg::entry_t'(rdata);
    act        = p1_inr_q && !cur.active && (p1_v_q > thr_q);
    tracked    = act || (p1_inr_q && cur.active);
    base_peak  = act ? p1_v_q : cur.peak;
    new_peak   = (p1_v_q > base_peak) ? p1_v_q : base_peak;
    new_stamp  = act ? p1_t_q : cur.stamp;
    deact      = tracked && (p1_lhs_q < CW'(new_peak));
    new_active = tracked && !deact;
    wr_entry.active = new_active;
    wr_entry.stamp  = new_stamp;
    wr_entry.peak   = tracked ? new_peak : cur.peak;
  end

  always_ff @(posedge clk_i) begin
    if (p1_adv && p1_inr_q) begin
      wb_node_q  <= p1_node_q;
      wb_entry_q <= wr_entry;
    end
    if (p1_adv) begin
      p2_node_q   <= p1_node_q;
      p2_act_q    <= act;
      p2_deact_q  <= deact;
      p2_active_q <= new_active;
      p2_peak_q   <= tracked ? new_peak : '0;
      p2_t_q      <= p1_t_q;
      p2_stamp_q  <= new_stamp;
      p2_any_q    <= seen_q | act;
    end
  end

  // ---------------------------------------------------------------- stage 2 duration
  assign diff  = {1'b0, p2_t_q} - {1'b0, p2_stamp_q};
  assign dur_d = (p2_deact_q && !diff[TW]) ? diff[TW-1:0] : '0;

  always_ff @(posedge clk_i) begin
    if (p2_adv) begin
      out_node_q   <= p2_node_q;
      out_act_q    <= p2_act_q;
      out_deact_q  <= p2_deact_q;
      out_active_q <= p2_active_q;
      out_peak_q   <= p2_peak_q;
      out_dur_q    <= dur_d;
      out_any_q    <= p2_any_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_node_o      = out_node_q;
  assign activated_o     = out_act_q;
  assign deactivated_o   = out_deact_q;
  assign is_active_o     = out_active_q;
  assign peak_out_o      = out_peak_q;
  assign duration_out_o  = out_dur_q;
  assign any_activated_o = out_any_q;

  // ---------------------------------------------------------------- assertions
  `APD_ASSERT_IMPL(a_deact_clears_active, out_valid_o && deactivated_o, !is_active_o,
    "node still active after repolarisation")
  `APD_ASSERT_IMPL(a_dur_zero, out_valid_o && !deactivated_o, duration_out_o == '0,
    "duration reported without deactivation")
  `APD_ASSERT_IMPL(a_act_seen, out_valid_o && activated_o, any_activated_o,
    "activation not recorded as seen")
  `APD_ASSERT_IMPL(a_clear_empty, clr_q, !p1_valid_q && !p2_valid_q,
    "request in flight during clearing pass")

endmodule

[verif/apd90_checker.sv]
// Checker for the APD90 tracker: follows the config writes and the sample requests,
// predicts each result from its own per-node state and compares the result channel.
// Depends on apd_pkg for widths, register indexes and the voltage type.
module apd90_checker
  import apd_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic [NODE_W-1:0]        node_index_i,
  input  logic [VOLT_W-1:0]        sample_voltage_i,
  input  logic [TIME_W-1:0]        sample_time_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic [NODE_W-1:0]        out_node_i,
  input  logic                     activated_i,
  input  logic                     deactivated_i,
  input  logic                     is_active_i,
  input  logic [VOLT_W-1:0]        peak_out_i,
  input  logic [TIME_W-1:0]        duration_out_i,
  input  logic                     any_activated_i,
  output int unsigned              fail_count_o,
  output int unsigned              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic              activated;
    logic              deactivated;
    logic              active;
    volt_t             peak;
    logic [TIME_W-1:0] duration;
    logic              any;
  } apd_result_t;

  logic              node_active [NODES];
  logic [TIME_W-1:0] onset_time  [NODES];
  volt_t             node_peak   [NODES];
  logic              ever_activated;
  volt_t             threshold_q;
  volt_t             resting_q;

  apd_result_t       expected_results [$];
  apd_result_t       oldest;

  function automatic apd_result_t track_sample(logic [NODE_W-1:0] node, volt_t v,
                                               logic [TIME_W-1:0] t);
    apd_result_t r;
    logic        tracked;
    longint      scaled_v;
    longint      level;
    r       = '0;
    tracked = 1'b0;
    r.node  = node;
    if (node < NODES) begin
      if (!node_active[node] && v > threshold_q) begin
        node_active[node] = 1'b1;
        onset_time[node]  = t;
        node_peak[node]   = v;
        ever_activated    = 1'b1;
        r.activated       = 1'b1;
      end
      if (node_active[node]) begin
        tracked = 1'b1;
        if (v > node_peak[node]) node_peak[node] = v;
        scaled_v = longint'(v) * 10;
        level    = longint'(node_peak[node]) + longint'(resting_q) * 9;
        if (scaled_v < level) begin
          node_active[node] = 1'b0;
          r.deactivated     = 1'b1;
          if (t >= onset_time[node]) r.duration = t - onset_time[node];
        end
      end
      r.active = node_active[node];
      if (tracked) r.peak = node_peak[node];
    end
    r.any = ever_activated;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < NODES; n++) node_active[n] = 1'b0;
      ever_activated = 1'b0;
      threshold_q    = THRESHOLD_RST;
      resting_q      = volt_t'(-21760);
      expected_results.delete();
      pending_o      = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual node %0h", $time,
                   out_node_i);
          fail_count_o++;
        end else begin
          oldest = expected_results.pop_front();
          check_field("out_node", 32'(oldest.node), 32'(out_node_i));
          check_field("activated", 32'(oldest.activated), 32'(activated_i));
          check_field("deactivated", 32'(oldest.deactivated), 32'(deactivated_i));
          check_field("is_active", 32'(oldest.active), 32'(is_active_i));
          check_field("peak_out", 32'(unsigned'(oldest.peak)), 32'(peak_out_i));
          check_field("duration_out", oldest.duration, duration_out_i);
          check_field("any_activated", 32'(oldest.any), 32'(any_activated_i));
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_THRESHOLD: threshold_q = cfg_data_i;
          REG_RESTING:   resting_q   = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        expected_results.push_back(track_sample(node_index_i, sample_voltage_i,
                                                sample_time_i));
      end
      pending_o = expected_results.size();
    end
  end

endmodule

[verif/tb_action_potential_apd90_tracker_top.sv]
// Testbench top of the APD90 tracker: clock, reset, config phases and sample requests
// with random gaps and output stalls; the verdict comes from the failure count of
// apd90_checker. Depends on apd_pkg, apd90_checker and the tracker RTL.
module tb_action_potential_apd90_tracker_top
  import apd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [NODE_W-1:0]      node_index;
  logic [VOLT_W-1:0]      sample_voltage;
  logic [TIME_W-1:0]      sample_time;
  logic                   out_valid;
  logic                   out_ready;
  logic [NODE_W-1:0]      out_node;
  logic                   activated;
  logic                   deactivated;
  logic                   is_active;
  logic [VOLT_W-1:0]      peak_out;
  logic [TIME_W-1:0]      duration_out;
  logic                   any_activated;
  int unsigned            fail_count;
  int unsigned            pending;
  logic                   quiet = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  action_potential_apd90_tracker_top uut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .node_index_i     (node_index),
    .sample_voltage_i (sample_voltage),
    .sample_time_i    (sample_time),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .out_node_o       (out_node),
    .activated_o      (activated),
    .deactivated_o    (deactivated),
    .is_active_o      (is_active),
    .peak_out_o       (peak_out),
    .duration_out_o   (duration_out),
    .any_activated_o  (any_activated)
  );

  apd90_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .node_index_i     (node_index),
    .sample_voltage_i (sample_voltage),
    .sample_time_i    (sample_time),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_node_i       (out_node),
    .activated_i      (activated),
    .deactivated_i    (deactivated),
    .is_active_i      (is_active),
    .peak_out_i       (peak_out),
    .duration_out_i   (duration_out),
    .any_activated_i  (any_activated),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  task automatic take_sample(input logic [NODE_W-1:0] node, input logic [VOLT_W-1:0] v,
                             input logic [TIME_W-1:0] t);
    @(negedge clk);
    in_valid       = 1'b1;
    node_index     = node;
    sample_voltage = v;
    sample_time    = t;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic hold_off(input int unsigned cycles);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic settle();
    hold_off(1);
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  function automatic logic [VOLT_W-1:0] shape_voltage(int thr, int rest);
    logic [VOLT_W-1:0] raw;
    longint            x;
    int unsigned       pick;
    raw  = VOLT_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 12) return raw;
    if (pick < 40) x = longint'(thr) + 1 + longint'($urandom_range(0, 8000));
    else if (pick < 65) x = longint'(thr) - longint'($urandom_range(0, 3000));
    else x = longint'(rest) - 600 + longint'($urandom_range(0, 1200));
    if (x > 131071) x = 131071;
    else if (x < -131072) x = -131072;
    return VOLT_W'(x);
  endfunction

  task automatic run_phase(input int thr, input int rest, input int unsigned count);
    logic [NODE_W-1:0] pool [8];
    logic [NODE_W-1:0] node;
    logic [TIME_W-1:0] tick;
    logic [TIME_W-1:0] t;
    logic              gappy;
    settle();
    write_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(REG_RESTING, CFG_DATA_W'(rest));
    foreach (pool[k]) pool[k] = NODE_W'($urandom_range(0, NODES - 1));
    tick  = $urandom_range(0, 1) ? TIME_W'($urandom) : '0;
    gappy = 1'b0;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 25 == 0) gappy = 1'($urandom_range(0, 1));
      if (!quiet && gappy && $urandom_range(0, 2) == 0) hold_off($urandom_range(1, 13));
      node = ($urandom_range(0, 4) == 0) ? NODE_W'($urandom_range(0, NODES - 1))
                                         : pool[$urandom_range(0, 7)];
      tick = tick + $urandom_range(0, 60);
      t    = ($urandom_range(0, 19) == 0) ? TIME_W'($urandom) : tick;
      take_sample(node, shape_voltage(thr, rest), t);
    end
  endtask

  initial begin
    int unsigned hold_cycles;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = 1'b1;
      if (!quiet) begin
        hold_cycles = $urandom_range(0, 3) == 0 ? $urandom_range(40, 150)
                                                : $urandom_range(1, 30);
        repeat (hold_cycles - 1) @(negedge clk);
        if (!quiet) begin
          @(negedge clk);
          out_ready = 1'b0;
          repeat ($urandom_range(1, 13) - 1) @(negedge clk);
        end
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    node_index     = '0;
    sample_voltage = '0;
    sample_time    = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    take_sample(10'd0, 18'(131071), 32'd0);
    take_sample(10'd0, 18'(50000), 32'd10);
    take_sample(10'd0, 18'(-131072), 32'd100);
    take_sample(10'd1023, 18'(1), 32'hFFFF_FFFF);
    take_sample(10'd1023, 18'(-131072), 32'd5);
    take_sample(10'd5, 18'(0), 32'd0);
    take_sample(10'd5, 18'(-131072), 32'd1);
    take_sample(10'd512, 18'(200), 32'd1000);
    take_sample(10'd512, 18'(300), 32'd1001);
    take_sample(10'd512, 18'(250), 32'd1002);
    take_sample(10'd512, 18'(-19554), 32'd1004);
    take_sample(10'd512, 18'(-19555), 32'd1005);
    take_sample(10'd682, 18'h15555, 32'hAAAA_AAAA);
    take_sample(10'd341, 18'h2AAAA, 32'h5555_5555);

    settle();
    write_reg(REG_THRESHOLD, CFG_DATA_W'(-131072));
    write_reg(REG_RESTING, CFG_DATA_W'(131071));
    write_reg(REG_SPARE_A, CFG_DATA_W'($urandom));
    write_reg(REG_SPARE_B, CFG_DATA_W'($urandom));
    take_sample(10'd7, 18'(0), 32'd20);
    take_sample(10'd7, 18'(-131072), 32'd21);
    take_sample(10'd7, 18'(131071), 32'd22);
    take_sample(10'd7, 18'(131071), 32'd30);
    take_sample(10'd7, 18'(131070), 32'd40);

    run_phase(-10240, -21760, 85);
    run_phase(131071, -131072, 85);
    run_phase(-131072, 131071, 85);
    run_phase(int'($signed(18'($urandom))), int'($signed(18'($urandom))), 85);
    run_phase(0, -131072, 85);
    quiet = 1'b1;
    run_phase(-12800, -20480, 85);
    settle();

    if (fail_count == 0) begin
      $display("action_potential_apd90_tracker_top regression: pass");
    end else begin
      $display("action_potential_apd90_tracker_top regression: fail");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("action_potential_apd90_tracker_top regression: fail");
    $finish;
  end

endmodule
